// File: rtl/wkgc_pkg.sv
// Shared constants, codes and a helper function for the weighted k-NN classifier.
package wkgc_pkg;

    localparam int FIELD_BITS  = 28;
    localparam int LABEL_BITS  = 3;
    localparam int DIST_BITS   = 62;
    localparam int CLASS_COUNT = 6;
    localparam int VOTE_BITS   = 7;
    localparam int TDATA_IN_W  = 240;
    localparam int TDATA_OUT_W = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [DIST_BITS-1:0]  DIST_MAX         = '1;
    localparam logic [LABEL_BITS-1:0] BACKGROUND_CLASS = 3'd5;

    localparam logic [CFG_ADDR_W-1:0] CFG_TEMPLATES_IN_USE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEIGHBORS_K      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VOTE_THRESHOLD   = 2'd2;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // weights 1,1,2,2,2,4,4,4 as left shifts
    function automatic logic [1:0] chan_weight_shift(input int unsigned ch);
        logic [1:0] sh;
        case (ch)
            0, 1:    sh = 2'd0;
            2, 3, 4: sh = 2'd1;
            default: sh = 2'd2;
        endcase
        return sh;
    endfunction

endpackage

// File: rtl/weighted_knn_gesture_classifier_core.sv
// Weighted k-nearest-neighbor gesture classifier: template store, sequencer and vote logic.
//
// Input channel (s_axis): one item is either a template load (tuser = 0) or a
// classify request (tuser = 1). Loads write the eight channel readings and the
// class label into a template slot and give no result; a slot past the store
// is dropped. A classify gives exactly one result item on m_axis: gesture 1-5,
// or 0 when background wins or no class reaches the vote threshold.
// Config port: i_cfg_we writes register i_cfg_addr (0 templates in use,
// 1 neighbor count k, 2 vote threshold); write only while the block is idle.
// A load writes the channels one by one in ST_LOAD. A classify runs every channel
// of every template through the shared subtract/square/accumulate unit (read,
// difference, square, accumulate), then offers the template to the k-best list,
// and finally counts votes; the template memory read port and the single
// multiplier set its speed.
// One item is in work at a time; s_axis_tready is high only while idle.
// The result sits in an output register; a stalled receiver holds the
// sequencer in ST_DONE before it posts the next result, and the block takes no
// new item meanwhile. Reset clears the config registers to 180 / 48 / 8, the
// state, the output valid flag and the sequencer indices; the template store is
// not cleared and must be loaded before the slots in use are classified against.
module weighted_knn_gesture_classifier_core
    import wkgc_pkg::*;
#(
    parameter int TEMPLATE_SLOTS = 256,
    parameter int MAX_NEIGHBORS  = 64,
    parameter int CHANNELS       = 8,
    parameter int SAMPLE_BITS    = 28
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] slot, [10:8] class_label, then chan0..chan7 at 28 bits each from bit 11
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
    // [0] command
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [2:0] gesture
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAW  = $clog2(TEMPLATE_SLOTS);
    localparam int SCW  = $clog2(TEMPLATE_SLOTS + 1);
    localparam int NAW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int NCW  = $clog2(MAX_NEIGHBORS + 1);
    localparam int TPLD = TEMPLATE_SLOTS * (2 ** CW);
    localparam int SQW  = 2 * SAMPLE_BITS;
    localparam int NBW  = LABEL_BITS + DIST_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_SETUP, ST_D_RD, ST_D_DIF, ST_D_MUL, ST_D_ACC,
        ST_I_START, ST_I_CHK, ST_I_RD, ST_I_CMP, ST_I_WR, ST_V_RD, ST_V_CNT, ST_DONE
    } t_state;

    t_state r_state;

    // config registers
    logic [8:0] r_tiu;
    logic [6:0] r_k_cfg;
    logic [6:0] r_thr;

    // item registers
    logic [7:0]             r_slot;
    logic [LABEL_BITS-1:0]  r_label;
    logic [SAMPLE_BITS-1:0] r_sample [CHANNELS];

    // sequencer registers
    logic [CW-1:0]  r_ch;
    logic [SCW-1:0] r_s;
    logic [SCW-1:0] r_n;
    logic [NCW-1:0] r_k;
    logic [NCW-1:0] r_used;
    logic [NAW-1:0] r_pos;
    logic [NCW-1:0] r_vi;

    // shared arithmetic
    logic [SAMPLE_BITS-1:0] r_diff;
    logic [SQW-1:0]         r_sq;
    logic [DIST_BITS-1:0]   r_sum;
    logic [LABEL_BITS-1:0]  r_cand_lbl;
    logic [VOTE_BITS-1:0]   r_votes [CLASS_COUNT];

    logic [LABEL_BITS-1:0]  r_gesture;
    logic [LABEL_BITS-1:0]  r_out_gesture;
    logic                   r_out_valid;
    logic                   out_free;

    // memories
    logic [SAMPLE_BITS-1:0] tpl_mem [TPLD];
    logic [LABEL_BITS-1:0]  lbl_mem [TEMPLATE_SLOTS];
    logic [NBW-1:0]         nb_mem  [MAX_NEIGHBORS];
    logic [SAMPLE_BITS-1:0] r_tpl_rd;
    logic [LABEL_BITS-1:0]  r_lbl_rd;
    logic [NBW-1:0]         r_nb_rd;

    logic [SAW+CW-1:0]      tpl_addr;
    logic                   tpl_we;
    logic                   lbl_we;
    logic [SAW-1:0]         lbl_addr;
    logic [NAW-1:0]         nb_ra;
    logic [NAW-1:0]         nb_wa;
    logic [NBW-1:0]         nb_wd;
    logic                   nb_we;
    logic                   slot_ok;

    logic [SAMPLE_BITS-1:0] in_chan [CHANNELS];
    logic [65:0]            term;
    logic [DIST_BITS-1:0]   term_sat;
    logic [DIST_BITS:0]     sum_ext;
    logic [DIST_BITS-1:0]   sum_sat;
    logic [VOTE_BITS-1:0]   votes_upd [CLASS_COUNT];
    logic                   win;
    logic [LABEL_BITS-1:0]  win_cls;
    logic [LABEL_BITS-1:0]  vote_lbl;
    logic [31:0]            n_calc;
    logic [31:0]            k_calc;

    // unpack the channel fields, masked or zero-extended to the sample width
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            for (int b = 0; b < SAMPLE_BITS; b++) begin
                in_chan[c][b] = (b < FIELD_BITS) ? s_axis_tdata[11 + FIELD_BITS * c + b] : 1'b0;
            end
        end
    end

    assign slot_ok = (32'(r_slot) < 32'(TEMPLATE_SLOTS));

    always_comb begin
        lbl_addr = r_s[SAW-1:0];
        tpl_addr = {r_s[SAW-1:0], r_ch};
        tpl_we   = 1'b0;
        lbl_we   = 1'b0;
        if (r_state == ST_LOAD) begin
            lbl_addr = SAW'(32'(r_slot));
            tpl_addr = {SAW'(32'(r_slot)), r_ch};
            tpl_we   = slot_ok;
            lbl_we   = slot_ok && (r_ch == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (tpl_we) begin
            tpl_mem[tpl_addr] <= r_sample[r_ch];
        end
        r_tpl_rd <= tpl_mem[tpl_addr];
    end

    always_ff @(posedge i_clk) begin
        if (lbl_we) begin
            lbl_mem[lbl_addr] <= r_label;
        end
        r_lbl_rd <= lbl_mem[lbl_addr];
    end

    // neighbor list port control
    always_comb begin
        nb_ra = r_vi[NAW-1:0];
        nb_wa = r_pos;
        nb_wd = {r_cand_lbl, r_sum};
        nb_we = 1'b0;
        case (r_state)
            ST_I_START: nb_ra = NAW'(r_k - 1'b1);
            ST_I_RD:    nb_ra = r_pos - 1'b1;
            ST_I_CMP: begin
                nb_wd = r_nb_rd;
                nb_we = (r_nb_rd[DIST_BITS-1:0] > r_sum);
            end
            ST_I_WR:    nb_we = 1'b1;
            default:    nb_ra = r_vi[NAW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (nb_we) begin
            nb_mem[nb_wa] <= nb_wd;
        end
        r_nb_rd <= nb_mem[nb_ra];
    end

    // weighted, saturating accumulate of the current channel term
    always_comb begin
        term     = 66'(r_sq) << chan_weight_shift(32'(r_ch));
        term_sat = (term > 66'(DIST_MAX)) ? DIST_MAX : term[DIST_BITS-1:0];
        sum_ext  = {1'b0, r_sum} + {1'b0, term_sat};
        sum_sat  = (sum_ext > {1'b0, DIST_MAX}) ? DIST_MAX : sum_ext[DIST_BITS-1:0];
    end

    // vote update and first-class-over-threshold check
    always_comb begin
        vote_lbl = r_nb_rd[NBW-1:DIST_BITS];
        win      = 1'b0;
        win_cls  = '0;
        for (int c = 0; c < CLASS_COUNT; c++) begin
            votes_upd[c] = r_votes[c] + ((32'(vote_lbl) == c) ? 7'd1 : 7'd0);
        end
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (votes_upd[c] >= r_thr) begin
                win     = 1'b1;
                win_cls = LABEL_BITS'(c);
            end
        end
    end

    always_comb begin
        n_calc = (32'(r_tiu) > 32'(TEMPLATE_SLOTS)) ? 32'(TEMPLATE_SLOTS) : 32'(r_tiu);
        k_calc = (32'(r_k_cfg) > 32'(MAX_NEIGHBORS)) ? 32'(MAX_NEIGHBORS) : 32'(r_k_cfg);
        if (k_calc > n_calc) begin
            k_calc = n_calc;
        end
    end

    // output register is free when empty or drained this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_OUT_W'(r_out_gesture);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tiu       <= 9'd180;
            r_k_cfg     <= 7'd48;
            r_thr       <= 7'd8;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
            r_s         <= '0;
            r_used      <= '0;
            r_vi        <= '0;
            r_pos       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TEMPLATES_IN_USE: r_tiu   <= i_cfg_wdata;
                    CFG_NEIGHBORS_K:      r_k_cfg <= i_cfg_wdata[6:0];
                    CFG_VOTE_THRESHOLD:   r_thr   <= i_cfg_wdata[6:0];
                    default:              r_tiu   <= r_tiu;
                endcase
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_slot  <= s_axis_tdata[7:0];
                        r_label <= s_axis_tdata[10:8];
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_sample[c] <= in_chan[c];
                        end
                        r_ch    <= '0;
                        r_state <= (s_axis_tuser == CMD_LOAD) ? ST_LOAD : ST_SETUP;
                    end
                end
                ST_LOAD: begin
                    if (32'(r_ch) == CHANNELS - 1) begin
                        r_ch    <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                ST_SETUP: begin
                    r_n    <= SCW'(n_calc);
                    r_k    <= NCW'(k_calc);
                    r_s    <= '0;
                    r_ch   <= '0;
                    r_sum  <= '0;
                    r_used <= '0;
                    r_vi   <= '0;
                    for (int c = 0; c < CLASS_COUNT; c++) begin
                        r_votes[c] <= '0;
                    end
                    r_state <= (k_calc == 0) ? ST_V_RD : ST_D_RD;
                end
                ST_D_RD:  r_state <= ST_D_DIF;
                ST_D_DIF: begin
                    r_diff  <= (r_sample[r_ch] > r_tpl_rd) ? (r_sample[r_ch] - r_tpl_rd)
                                                           : (r_tpl_rd - r_sample[r_ch]);
                    r_state <= ST_D_MUL;
                end
                ST_D_MUL: begin
                    r_sq    <= r_diff * r_diff;
                    r_state <= ST_D_ACC;
                end
                ST_D_ACC: begin
                    r_sum <= sum_sat;
                    if (32'(r_ch) == CHANNELS - 1) begin
                        r_ch       <= '0;
                        r_cand_lbl <= r_lbl_rd;
                        r_state    <= ST_I_START;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= ST_D_RD;
                    end
                end
                ST_I_START: begin
                    if (r_used == r_k) begin
                        r_state <= ST_I_CHK;
                    end else begin
                        r_pos   <= r_used[NAW-1:0];
                        r_state <= ST_I_RD;
                    end
                end
                ST_I_CHK: begin
                    if (r_sum < r_nb_rd[DIST_BITS-1:0]) begin
                        r_pos   <= NAW'(r_k - 1'b1);
                        r_state <= ST_I_RD;
                    end else begin
                        // not among the k nearest: move to the next slot
                        r_sum <= '0;
                        r_s   <= r_s + 1'b1;
                        r_state <= (r_s + 1'b1 == r_n) ? ST_V_RD : ST_D_RD;
                    end
                end
                ST_I_RD: begin
                    r_state <= (r_pos == '0) ? ST_I_WR : ST_I_CMP;
                end
                ST_I_CMP: begin
                    if (r_nb_rd[DIST_BITS-1:0] > r_sum) begin
                        r_pos   <= r_pos - 1'b1;
                        r_state <= ST_I_RD;
                    end else begin
                        r_state <= ST_I_WR;
                    end
                end
                ST_I_WR: begin
                    if (r_used != r_k) begin
                        r_used <= r_used + 1'b1;
                    end
                    r_sum   <= '0;
                    r_s     <= r_s + 1'b1;
                    r_state <= (r_s + 1'b1 == r_n) ? ST_V_RD : ST_D_RD;
                end
                ST_V_RD: begin
                    if (r_vi == r_used) begin
                        r_gesture <= '0;
                        r_state   <= ST_DONE;
                    end else begin
                        r_state <= ST_V_CNT;
                    end
                end
                ST_V_CNT: begin
                    for (int c = 0; c < CLASS_COUNT; c++) begin
                        r_votes[c] <= votes_upd[c];
                    end
                    if (win) begin
                        r_gesture <= (win_cls == BACKGROUND_CLASS) ? '0 : win_cls + 1'b1;
                        r_state   <= ST_DONE;
                    end else begin
                        r_vi    <= r_vi + 1'b1;
                        r_state <= ST_V_RD;
                    end
                end
                ST_DONE: begin
                    // post only once the previous result has left
                    if (out_free) begin
                        r_out_gesture <= r_gesture;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: test/weighted_knn_gesture_classifier_core_tb.sv
// Self-checking testbench for the weighted k-NN gesture classifier core.
`timescale 1ns / 1ps

module weighted_knn_gesture_classifier_core_tb;
    import wkgc_pkg::*;

    typedef logic [7:0][FIELD_BITS-1:0] t_chans;

    localparam int SLOTS    = 256;
    localparam int MAX_K    = 64;
    localparam int SETTLE   = 40;  // covers the channel writes of a load with margin

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [7:0] slot, [10:8] class_label, [234:11] chan0..chan7, rest zero
    logic [TDATA_IN_W-1:0]  s_axis_tdata;
    // [0] command
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [2:0] gesture
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    weighted_knn_gesture_classifier_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Shadow of the block: template store and config registers.
    t_chans          tmpl_chans [SLOTS];
    logic [2:0]      tmpl_label [SLOTS];
    logic [8:0]      n_templates = 9'd180;
    logic [6:0]      k_neighbors = 7'd48;
    logic [6:0]      vote_thr    = 7'd8;
    logic [2:0]      gesture_q [$];   // gestures still owed by the block
    t_chans          class_center [8];
    int              err_count   = 0;
    int              burst_left  = 0;
    int              rx_hold     = 0; // long receiver hold-off, in cycles

    // Weighted squared distance, weights 1,1,2,2,2,4,4,4.
    function automatic logic [63:0] wdist(input t_chans a, input t_chans b);
        logic [63:0] sum;
        logic [63:0] diff;
        sum = '0;
        for (int c = 0; c < 8; c++) begin
            diff = (a[c] > b[c]) ? 64'(a[c] - b[c]) : 64'(b[c] - a[c]);
            sum += (diff * diff) << ((c < 2) ? 0 : (c < 5) ? 1 : 2);
        end
        return sum;
    endfunction

    // Expected gesture for a classify against the shadow store.
    function automatic logic [2:0] predict_gesture(input t_chans smp);
        logic [63:0] best_d [MAX_K];
        logic [2:0]  best_l [MAX_K];
        int          votes  [6];
        int          n, k, used, pos;
        logic [63:0] d;
        n = (n_templates > SLOTS) ? SLOTS : n_templates;
        k = (k_neighbors > MAX_K) ? MAX_K : k_neighbors;
        if (k > n) k = n;
        used = 0;
        for (int s = 0; s < n && k > 0; s++) begin
            d = wdist(smp, tmpl_chans[s]);
            if (used == k && !(d < best_d[k-1])) continue;
            pos = (used < k) ? used : k - 1;
            // strict compare keeps the lower slot ahead on equal distance
            while (pos > 0 && best_d[pos-1] > d) begin
                best_d[pos] = best_d[pos-1];
                best_l[pos] = best_l[pos-1];
                pos--;
            end
            best_d[pos] = d;
            best_l[pos] = tmpl_label[s];
            if (used < k) used++;
        end
        foreach (votes[c]) votes[c] = 0;
        for (int i = 0; i < used; i++) begin
            if (best_l[i] < 6) votes[best_l[i]]++;   // labels 6 and 7 never vote
            for (int c = 0; c < 6; c++)
                if (votes[c] >= vote_thr)
                    return (c == BACKGROUND_CLASS) ? 3'd0 : 3'(c + 1);
        end
        return 3'd0;
    endfunction

    // Sends one item in bursts with random gaps; updates the shadow on acceptance.
    task automatic send_item(input logic cmd, input logic [7:0] slot,
                             input logic [2:0] label, input t_chans ch);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'd0, ch, label, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_LOAD) begin
            tmpl_chans[slot] = ch;
            tmpl_label[slot] = label;
        end else begin
            gesture_q.push_back(predict_gesture(ch));
        end
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            burst_left = $urandom_range(0, 10);
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // Block idle: nothing owed, input lowered, load pipeline drained.
    task automatic wait_idle();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (gesture_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= CFG_DATA_W'(val);
        case (addr)
            CFG_TEMPLATES_IN_USE: n_templates = 9'(val);
            CFG_NEIGHBORS_K:      k_neighbors = 7'(val);
            CFG_VOTE_THRESHOLD:   vote_thr    = 7'(val);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_cfg(input int unsigned n, input int unsigned k, input int unsigned thr);
        wait_idle();
        write_cfg(CFG_TEMPLATES_IN_USE, n);
        write_cfg(CFG_NEIGHBORS_K, k);
        write_cfg(CFG_VOTE_THRESHOLD, thr);
    endtask

    function automatic t_chans rand_chans();
        t_chans ch;
        for (int c = 0; c < 8; c++) ch[c] = FIELD_BITS'($urandom);
        return ch;
    endfunction

    // Small jitter around a point, clamped to the field range.
    function automatic t_chans jitter(input t_chans base);
        t_chans ch;
        int     v;
        for (int c = 0; c < 8; c++) begin
            v = int'(base[c]) + int'($urandom_range(0, 4095)) - 2048;
            if (v < 0) v = 0;
            if (v > 32'h0fff_ffff) v = 32'h0fff_ffff;
            ch[c] = FIELD_BITS'(v);
        end
        return ch;
    endfunction

    function automatic t_chans fill_chans(input logic [27:0] v);
        t_chans ch;
        for (int c = 0; c < 8; c++) ch[c] = v;
        return ch;
    endfunction

    // Templates mostly around per-class centers (a quarter random), so votes cluster meaningfully.
    task automatic load_random(input int slot);
        logic [2:0] lab;
        lab = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0)
            send_item(CMD_LOAD, 8'(slot), lab, rand_chans());
        else
            send_item(CMD_LOAD, 8'(slot), lab, jitter(class_center[lab]));
    endtask

    task automatic classify_random(input int n);
        int s;
        s = $urandom_range(0, (n > 0) ? n - 1 : 0);
        if ($urandom_range(0, 9) < 6)
            send_item(CMD_CLASSIFY, 8'($urandom), 3'($urandom), jitter(tmpl_chans[s]));
        else
            send_item(CMD_CLASSIFY, 8'($urandom), 3'($urandom), rand_chans());
    endtask

    // Directed templates in slots 0-7: corners, a tie pair, the unused labels.
    task automatic test_directed_loads();
        send_item(CMD_LOAD, 8'd0, 3'd0, fill_chans(28'd0));
        send_item(CMD_LOAD, 8'd1, 3'd5, fill_chans(28'hfff_ffff));
        send_item(CMD_LOAD, 8'd2, 3'd6, fill_chans(28'h555_5555));
        send_item(CMD_LOAD, 8'd3, 3'd7, fill_chans(28'haaa_aaaa));
        send_item(CMD_LOAD, 8'd4, 3'd1, fill_chans(28'd0));  // ties slot 0
        send_item(CMD_LOAD, 8'd5, 3'd2, fill_chans(28'h800_0000));
        send_item(CMD_LOAD, 8'd6, 3'd3, fill_chans(28'h100_0000));
        send_item(CMD_LOAD, 8'd7, 3'd4, fill_chans(28'h010_0000));
    endtask

    task automatic test_fill_store();
        for (int s = 8; s < SLOTS; s++) load_random(s);
    endtask

    // No config writes yet: reset values 180 / 48 / 8 apply.
    task automatic test_reset_config();
        repeat (3) classify_random(180);
    endtask

    task automatic test_directed_classify();
        set_cfg(8, 8, 1);
        send_item(CMD_CLASSIFY, 8'hff, 3'd7, fill_chans(28'd0));        // tie: lower slot wins
        send_item(CMD_CLASSIFY, 8'h00, 3'd0, fill_chans(28'hfff_ffff)); // background
        set_cfg(8, 1, 1);
        send_item(CMD_CLASSIFY, 8'd0, 3'd0, fill_chans(28'h555_5555));  // label 6 casts no vote
        send_item(CMD_CLASSIFY, 8'd0, 3'd0, fill_chans(28'haaa_aaaa));  // label 7 likewise
        set_cfg(8, 8, 0);                                               // threshold zero
        send_item(CMD_CLASSIFY, 8'd0, 3'd0, fill_chans(28'h800_0000));
        set_cfg(0, 8, 1);                                               // no templates
        send_item(CMD_CLASSIFY, 8'd0, 3'd0, fill_chans(28'd0));
        set_cfg(8, 0, 1);                                               // k zero
        send_item(CMD_CLASSIFY, 8'd0, 3'd0, fill_chans(28'd0));
        set_cfg(8, 127, 127);                                           // k clamp, no winner
        send_item(CMD_CLASSIFY, 8'd0, 3'd0, fill_chans(28'h100_0000));
        set_cfg(511, 127, 64);                                          // clamps to full store
        send_item(CMD_CLASSIFY, 8'd0, 3'd0, rand_chans());
        set_cfg(256, 64, 1);
        send_item(CMD_CLASSIFY, 8'd0, 3'd0, fill_chans(28'h010_0000));
    endtask

    // Receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        set_cfg(4, 4, 2);
        rx_hold = 3000;
        repeat (4) classify_random(4);
        repeat (2) load_random($urandom_range(0, 255));
        repeat (2) classify_random(4);
    endtask

    task automatic test_random_traffic();
        int n, k, thr;
        for (int ph = 0; ph < 20; ph++) begin
            n   = (ph % 7 == 6) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            k   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, n);
            thr = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
            set_cfg(n, k, thr);
            repeat (58) begin
                if ($urandom_range(0, 9) < 4) load_random($urandom_range(0, 255));
                else classify_random(n);
            end
        end
    endtask

    // Result checker and receiver stall pattern.
    int rx_mode  = 0;
    int rx_count = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (gesture_q.size() == 0) begin
                    $error("unexpected result: gesture %0d", m_axis_tdata[2:0]);
                    err_count++;
                end else if (m_axis_tdata[2:0] !== gesture_q[0]) begin
                    $error("gesture mismatch: expected %0d, actual %0d",
                           gesture_q[0], m_axis_tdata[2:0]);
                    err_count++;
                    void'(gesture_q.pop_front());
                end else begin
                    void'(gesture_q.pop_front());
                end
            end
            rx_count++;
            if (rx_count % 97 == 0) rx_mode = $urandom_range(0, 2);
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom);
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_LOAD;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_TEMPLATES_IN_USE;
        i_cfg_wdata   <= '0;
        for (int c = 0; c < 8; c++) class_center[c] = rand_chans();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_loads();
        test_fill_store();
        test_reset_config();
        test_directed_classify();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
